### design/char_buffer_find_and_substring_match_macros.svh
// assertion macros for the text buffer block
`ifndef CHAR_BUFFER_FIND_AND_SUBSTRING_MATCH_MACROS_SVH
`define CHAR_BUFFER_FIND_AND_SUBSTRING_MATCH_MACROS_SVH

// same-cycle implication
`define CBFSM_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cbfsm check failed");

// next-cycle implication
`define CBFSM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cbfsm check failed");

`endif

### design/cbfsm_pkg.sv
`default_nettype none

package cbfsm_pkg;

    localparam int TEXT_DEPTH    = 256;
    localparam int PATTERN_DEPTH = 64;

    localparam int TEXT_AW = (TEXT_DEPTH > 1) ? $clog2(TEXT_DEPTH) : 1;
    localparam int TEXT_CW = $clog2(TEXT_DEPTH + 1);
    localparam int PAT_AW  = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
    localparam int PAT_CW  = $clog2(PATTERN_DEPTH + 1);
    localparam int SUM_W   = ((TEXT_CW > PAT_CW) ? TEXT_CW : PAT_CW) + 1;

    localparam int CMD_W = 3;
    localparam int CH_W  = 8;
    localparam int LEN_W = 9;
    localparam int POS_W = 8;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_CLR_T,
        OP_WR_T,
        OP_CLR_P,
        OP_WR_P,
        OP_SET_OVF,
        OP_ZERO_I,
        OP_RD_FIND,
        OP_HIT,
        OP_INC_I,
        OP_ZERO_S,
        OP_SET_FOUND,
        OP_ZERO_K,
        OP_RD_MATCH,
        OP_INC_K,
        OP_INC_S,
        OP_EMIT
    } op_t;

    typedef struct packed {
        op_t op;
    } ctl_t;

    typedef struct packed {
        logic             in_valid;
        logic [CMD_W-1:0] command;
        logic             text_full;
        logic             pat_full;
        logic             text_end;
        logic             byte_eq;
        logic             pat_empty;
        logic             no_room;
        logic             pat_end;
        logic             pair_eq;
        logic             out_free;
    } status_t;

endpackage

`default_nettype wire

### design/cbfsm_if.sv
`default_nettype none

interface cbfsm_cmd_if;
    import cbfsm_pkg::*;

    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] command;
    logic [CH_W-1:0]  ch;

    modport source (output valid, output command, output ch, input ready);
    modport sink   (input valid, input command, input ch, output ready);
endinterface

interface cbfsm_res_if;
    import cbfsm_pkg::*;

    logic             valid;
    logic             ready;
    logic [LEN_W-1:0] text_len;
    logic             found;
    logic [POS_W-1:0] position;
    logic             overflow;

    modport source (output valid, output text_len, output found, output position,
                    output overflow, input ready);
    modport sink   (input valid, input text_len, input found, input position,
                    input overflow, output ready);
endinterface

`default_nettype wire

### design/cbfsm_seq.sv
`default_nettype none

module cbfsm_seq (
    input  logic               clk,
    input  logic               rst_n,
    input  cbfsm_pkg::status_t status,
    output cbfsm_pkg::ctl_t    ctl
);
    import cbfsm_pkg::*;

    localparam logic [CMD_W-1:0] CMD_CLEAR_TEXT     = CMD_W'(0);
    localparam logic [CMD_W-1:0] CMD_APPEND_TEXT    = CMD_W'(1);
    localparam logic [CMD_W-1:0] CMD_CLEAR_PATTERN  = CMD_W'(2);
    localparam logic [CMD_W-1:0] CMD_APPEND_PATTERN = CMD_W'(3);
    localparam logic [CMD_W-1:0] CMD_FIND           = CMD_W'(4);
    localparam logic [CMD_W-1:0] CMD_MATCH          = CMD_W'(5);

    typedef enum logic [4:0] {
        S_IDLE,
        S_CLR_T,
        S_APP_T,
        S_APP_T_WR,
        S_CLR_P,
        S_APP_P,
        S_APP_P_WR,
        S_OVF,
        S_FIND,
        S_FIND_RD,
        S_FIND_CMP,
        S_FIND_HIT,
        S_FIND_NEXT,
        S_MATCH,
        S_MATCH_HIT,
        S_MATCH_CHK,
        S_MATCH_RD,
        S_MATCH_CMP,
        S_MATCH_NEXTK,
        S_MATCH_NEXTS,
        S_RESP
    } step_t;

    typedef enum logic [3:0] {
        COND_ALWAYS,
        COND_DISPATCH,
        COND_TEXT_FULL,
        COND_PAT_FULL,
        COND_TEXT_END,
        COND_BYTE_EQ,
        COND_PAT_EMPTY,
        COND_NO_ROOM,
        COND_PAT_END,
        COND_PAIR_EQ,
        COND_OUT_FREE
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t jmp;
        step_t nxt;
    } uword_t;

    // control store: jmp if cond holds, else nxt; dispatch decodes cmd
    function automatic uword_t rom(input step_t s);
        uword_t w;
        unique case (s)
            S_IDLE:        w = '{OP_LOAD,      COND_DISPATCH,  S_IDLE,        S_IDLE};
            S_CLR_T:       w = '{OP_CLR_T,     COND_ALWAYS,    S_RESP,        S_RESP};
            S_APP_T:       w = '{OP_NONE,      COND_TEXT_FULL, S_OVF,         S_APP_T_WR};
            S_APP_T_WR:    w = '{OP_WR_T,      COND_ALWAYS,    S_RESP,        S_RESP};
            S_CLR_P:       w = '{OP_CLR_P,     COND_ALWAYS,    S_RESP,        S_RESP};
            S_APP_P:       w = '{OP_NONE,      COND_PAT_FULL,  S_OVF,         S_APP_P_WR};
            S_APP_P_WR:    w = '{OP_WR_P,      COND_ALWAYS,    S_RESP,        S_RESP};
            S_OVF:         w = '{OP_SET_OVF,   COND_ALWAYS,    S_RESP,        S_RESP};
            S_FIND:        w = '{OP_ZERO_I,    COND_ALWAYS,    S_FIND_RD,     S_FIND_RD};
            S_FIND_RD:     w = '{OP_RD_FIND,   COND_TEXT_END,  S_RESP,        S_FIND_CMP};
            S_FIND_CMP:    w = '{OP_NONE,      COND_BYTE_EQ,   S_FIND_HIT,    S_FIND_NEXT};
            S_FIND_HIT:    w = '{OP_HIT,       COND_ALWAYS,    S_RESP,        S_RESP};
            S_FIND_NEXT:   w = '{OP_INC_I,     COND_ALWAYS,    S_FIND_RD,     S_FIND_RD};
            S_MATCH:       w = '{OP_ZERO_S,    COND_PAT_EMPTY, S_MATCH_HIT,   S_MATCH_CHK};
            S_MATCH_HIT:   w = '{OP_SET_FOUND, COND_ALWAYS,    S_RESP,        S_RESP};
            S_MATCH_CHK:   w = '{OP_ZERO_K,    COND_NO_ROOM,   S_RESP,        S_MATCH_RD};
            S_MATCH_RD:    w = '{OP_RD_MATCH,  COND_PAT_END,   S_MATCH_HIT,   S_MATCH_CMP};
            S_MATCH_CMP:   w = '{OP_NONE,      COND_PAIR_EQ,   S_MATCH_NEXTK, S_MATCH_NEXTS};
            S_MATCH_NEXTK: w = '{OP_INC_K,     COND_ALWAYS,    S_MATCH_RD,    S_MATCH_RD};
            S_MATCH_NEXTS: w = '{OP_INC_S,     COND_ALWAYS,    S_MATCH_CHK,   S_MATCH_CHK};
            S_RESP:        w = '{OP_EMIT,      COND_OUT_FREE,  S_IDLE,        S_RESP};
            default:       w = '{OP_NONE,      COND_ALWAYS,    S_IDLE,        S_IDLE};
        endcase
        return w;
    endfunction

    function automatic step_t dispatch(input logic [CMD_W-1:0] c);
        step_t s;
        unique case (c)
            CMD_CLEAR_TEXT:     s = S_CLR_T;
            CMD_APPEND_TEXT:    s = S_APP_T;
            CMD_CLEAR_PATTERN:  s = S_CLR_P;
            CMD_APPEND_PATTERN: s = S_APP_P;
            CMD_FIND:           s = S_FIND;
            CMD_MATCH:          s = S_MATCH;
            default:            s = S_RESP;
        endcase
        return s;
    endfunction

    step_t  step_reg;
    step_t  step_next;
    uword_t word;
    logic   taken;

    always_comb
    begin
        word = rom(step_reg);
        unique case (word.cond)
            COND_ALWAYS:    taken = 1'b1;
            COND_DISPATCH:  taken = 1'b0;
            COND_TEXT_FULL: taken = status.text_full;
            COND_PAT_FULL:  taken = status.pat_full;
            COND_TEXT_END:  taken = status.text_end;
            COND_BYTE_EQ:   taken = status.byte_eq;
            COND_PAT_EMPTY: taken = status.pat_empty;
            COND_NO_ROOM:   taken = status.no_room;
            COND_PAT_END:   taken = status.pat_end;
            COND_PAIR_EQ:   taken = status.pair_eq;
            COND_OUT_FREE:  taken = status.out_free;
            default:        taken = 1'b0;
        endcase
        if (word.cond == COND_DISPATCH)
        begin
            step_next = status.in_valid ? dispatch(status.command) : S_IDLE;
        end
        else
        begin
            step_next = taken ? word.jmp : word.nxt;
        end
        ctl.op = word.op;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= S_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

`default_nettype wire

### design/cbfsm_dp.sv
`default_nettype none

module cbfsm_dp (
    input  logic               clk,
    input  logic               rst_n,
    cbfsm_cmd_if.sink          cmd,
    cbfsm_res_if.source        res,
    input  cbfsm_pkg::ctl_t    ctl,
    output cbfsm_pkg::status_t status
);
    import cbfsm_pkg::*;

    logic [CH_W-1:0]    text_mem [TEXT_DEPTH];
    logic [CH_W-1:0]    pat_mem  [PATTERN_DEPTH];

    logic [TEXT_CW-1:0] tc_reg;
    logic [PAT_CW-1:0]  pc_reg;
    logic [TEXT_CW-1:0] i_reg;
    logic [TEXT_CW-1:0] s_reg;
    logic [PAT_CW-1:0]  k_reg;
    logic [CH_W-1:0]    ch_reg;
    logic [CH_W-1:0]    trd_reg;
    logic [CH_W-1:0]    prd_reg;
    logic               found_reg;
    logic [POS_W-1:0]   pos_reg;
    logic               ovf_reg;

    logic               out_valid_reg;
    logic [LEN_W-1:0]   len_out_reg;
    logic               found_out_reg;
    logic [POS_W-1:0]   pos_out_reg;
    logic               ovf_out_reg;

    logic               fire;
    logic               out_free;
    logic               emit;
    logic [SUM_W-1:0]   tk_sum;
    logic [SUM_W-1:0]   end_sum;
    logic [TEXT_AW-1:0] t_rd_addr;
    logic               t_rd_en;

    assign cmd.ready = (ctl.op == OP_LOAD);
    assign fire      = cmd.valid && cmd.ready;
    assign out_free  = !out_valid_reg || res.ready;
    assign emit      = (ctl.op == OP_EMIT) && out_free;

    assign tk_sum    = SUM_W'(s_reg) + SUM_W'(k_reg);
    assign end_sum   = SUM_W'(s_reg) + SUM_W'(pc_reg);
    assign t_rd_en   = (ctl.op == OP_RD_FIND) || (ctl.op == OP_RD_MATCH);
    assign t_rd_addr = (ctl.op == OP_RD_MATCH) ? tk_sum[TEXT_AW-1:0] : i_reg[TEXT_AW-1:0];

    always_comb
    begin
        status.in_valid  = cmd.valid;
        status.command   = cmd.command;
        status.text_full = (tc_reg == TEXT_CW'(TEXT_DEPTH));
        status.pat_full  = (pc_reg == PAT_CW'(PATTERN_DEPTH));
        status.text_end  = (i_reg >= tc_reg);
        status.byte_eq   = (trd_reg == ch_reg);
        status.pat_empty = (pc_reg == '0);
        status.no_room   = (end_sum > SUM_W'(tc_reg));
        status.pat_end   = (k_reg == pc_reg);
        status.pair_eq   = (trd_reg == prd_reg);
        status.out_free  = out_free;
    end

    // text and pattern stores, registered read
    always_ff @(posedge clk)
    begin
        if (ctl.op == OP_WR_T)
        begin
            text_mem[tc_reg[TEXT_AW-1:0]] <= ch_reg;
        end
        if (t_rd_en)
        begin
            trd_reg <= text_mem[t_rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.op == OP_WR_P)
        begin
            pat_mem[pc_reg[PAT_AW-1:0]] <= ch_reg;
        end
        if (ctl.op == OP_RD_MATCH)
        begin
            prd_reg <= pat_mem[k_reg[PAT_AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tc_reg        <= '0;
            pc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (ctl.op)
                OP_CLR_T: tc_reg <= '0;
                OP_WR_T:  tc_reg <= tc_reg + TEXT_CW'(1);
                OP_CLR_P: pc_reg <= '0;
                OP_WR_P:  pc_reg <= pc_reg + PAT_CW'(1);
                default:  ;
            endcase
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (ctl.op)
            OP_LOAD:
            begin
                if (fire)
                begin
                    ch_reg    <= cmd.ch;
                    found_reg <= 1'b0;
                    pos_reg   <= '0;
                    ovf_reg   <= 1'b0;
                end
            end
            OP_SET_OVF:   ovf_reg <= 1'b1;
            OP_ZERO_I:    i_reg <= '0;
            OP_HIT:
            begin
                found_reg <= 1'b1;
                pos_reg   <= POS_W'(i_reg);
            end
            OP_INC_I:     i_reg <= i_reg + TEXT_CW'(1);
            OP_ZERO_S:    s_reg <= '0;
            OP_SET_FOUND: found_reg <= 1'b1;
            OP_ZERO_K:    k_reg <= '0;
            OP_INC_K:     k_reg <= k_reg + PAT_CW'(1);
            OP_INC_S:     s_reg <= s_reg + TEXT_CW'(1);
            default:      ;
        endcase
        if (emit)
        begin
            len_out_reg   <= LEN_W'(tc_reg);
            found_out_reg <= found_reg;
            pos_out_reg   <= pos_reg;
            ovf_out_reg   <= ovf_reg;
        end
    end

    assign res.valid    = out_valid_reg;
    assign res.text_len = len_out_reg;
    assign res.found    = found_out_reg;
    assign res.position = pos_out_reg;
    assign res.overflow = ovf_out_reg;

endmodule

`default_nettype wire

### design/char_buffer_find_and_substring_match.sv
// channel  modport  payload                               transfer
// cmd      sink     command[2:0], ch[7:0]                 valid && ready
// res      source   text_len[8:0], found, position[7:0],  valid && ready
//                   overflow
//
// one item at a time; clear and append run their own states, then emit from S_RESP
// find scans the text in three steps per byte: read, compare, advance
// match tries each start offset in turn and compares the pattern byte by byte
// rst_n clears both counts at once; the stores need no clearing pass
// a result waits in the output register while the next command is taken
`default_nettype none

module char_buffer_find_and_substring_match (
    input  logic        clk,
    input  logic        rst_n,
    cbfsm_cmd_if.sink   cmd,
    cbfsm_res_if.source res
);
    import cbfsm_pkg::*;

    ctl_t    ctl;
    status_t status;

    cbfsm_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctl    (ctl)
    );

    cbfsm_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .res    (res),
        .ctl    (ctl),
        .status (status)
    );

endmodule

`default_nettype wire

### design/cbfsm_chk.sv
`default_nettype none
`include "char_buffer_find_and_substring_match_macros.svh"

module cbfsm_chk (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic                        found,
    input logic [cbfsm_pkg::POS_W-1:0] position,
    input logic                        overflow
);
    import cbfsm_pkg::*;

    `CBFSM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
    `CBFSM_ASSERT_NEXT(a_busy_after_transfer, in_valid && in_ready, !in_ready)
    `CBFSM_ASSERT_SAME(a_ovf_alone, out_valid && overflow, !found && position == '0)
    `CBFSM_ASSERT_SAME(a_pos_needs_found, out_valid && position != '0, found)

endmodule

bind char_buffer_find_and_substring_match cbfsm_chk u_cbfsm_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (cmd.valid),
    .in_ready  (cmd.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .found     (res.found),
    .position  (res.position),
    .overflow  (res.overflow)
);

`default_nettype wire

### bench/char_buffer_find_and_substring_match_tb.sv
module char_buffer_find_and_substring_match_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cbfsm_pkg::*;

    localparam int ITEM_TARGET = 1550;
    localparam int IDLE_PCT    = 29;
    localparam int STALL_LIMIT = 200000;
    localparam int TAIL_CYCLES = 20;
    localparam int QUIET_FROM  = 700;
    localparam int QUIET_TO    = 1000;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLR_TEXT = 3'd0,
        CMD_ADD_TEXT = 3'd1,
        CMD_CLR_PAT  = 3'd2,
        CMD_ADD_PAT  = 3'd3,
        CMD_FIND     = 3'd4,
        CMD_MATCH    = 3'd5,
        CMD_RSV6     = 3'd6,
        CMD_RSV7     = 3'd7
    } buf_cmd_t;

    typedef enum int {
        SC_PAIR,
        SC_QUERY,
        SC_NOISE,
        SC_FILL_TEXT,
        SC_FILL_PAT
    } scen_t;

    typedef struct {
        buf_cmd_t        op;
        logic [CH_W-1:0] ch;
        bit              hold;
    } buf_item_t;

    typedef struct packed {
        logic [LEN_W-1:0] text_len;
        logic             found;
        logic [POS_W-1:0] position;
        logic             overflow;
    } buf_result_t;

    logic clk = 1'b0;
    logic rst_n;

    cbfsm_cmd_if cmd_ch();
    cbfsm_res_if res_ch();

    char_buffer_find_and_substring_match u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch)
    );

    always #5 clk = ~clk;

    // mirror of the two stores
    logic [CH_W-1:0] mirror_text [TEXT_DEPTH];
    logic [CH_W-1:0] mirror_pat  [PATTERN_DEPTH];
    int              mirror_text_cnt = 0;
    int              mirror_pat_cnt  = 0;

    buf_item_t   cmd_pending [$];
    buf_result_t res_expected [$];
    buf_item_t   drv_next;
    buf_result_t mon_want;

    bit hold_next   = 1'b0;
    int n_queued    = 0;
    int n_cmd_done  = 0;
    int n_res_done  = 0;
    int n_errors    = 0;
    int n_find      = 0;
    int n_find_hit  = 0;
    int n_match     = 0;
    int n_match_hit = 0;
    int n_overflow  = 0;
    int stall_cnt   = 0;

    wire quiet = (n_cmd_done >= QUIET_FROM) && (n_cmd_done < QUIET_TO);

    function automatic buf_result_t apply_buffer_cmd(buf_cmd_t op, logic [CH_W-1:0] b);
        buf_result_t r;
        bit          ok;
        r = '0;
        case (op)
            CMD_CLR_TEXT: mirror_text_cnt = 0;
            CMD_ADD_TEXT:
                if (mirror_text_cnt < TEXT_DEPTH) begin
                    mirror_text[mirror_text_cnt] = b;
                    mirror_text_cnt++;
                end else begin
                    r.overflow = 1'b1;
                end
            CMD_CLR_PAT: mirror_pat_cnt = 0;
            CMD_ADD_PAT:
                if (mirror_pat_cnt < PATTERN_DEPTH) begin
                    mirror_pat[mirror_pat_cnt] = b;
                    mirror_pat_cnt++;
                end else begin
                    r.overflow = 1'b1;
                end
            CMD_FIND:
                for (int i = 0; i < mirror_text_cnt && !r.found; i++) begin
                    if (mirror_text[i] == b) begin
                        r.found    = 1'b1;
                        r.position = POS_W'(i);
                    end
                end
            CMD_MATCH:
                if (mirror_pat_cnt == 0) begin
                    r.found = 1'b1;
                end else begin
                    for (int s = 0; s + mirror_pat_cnt <= mirror_text_cnt && !r.found; s++) begin
                        ok = 1'b1;
                        for (int k = 0; k < mirror_pat_cnt; k++) begin
                            if (mirror_text[s + k] != mirror_pat[k])
                                ok = 1'b0;
                        end
                        r.found = ok;
                    end
                end
            default: ;
        endcase
        r.text_len = LEN_W'(mirror_text_cnt);
        return r;
    endfunction

    function automatic logic [CH_W-1:0] pick_byte(bit narrow);
        if (narrow)
            return 8'h61 + CH_W'($urandom_range(0, 2));
        return CH_W'($urandom_range(0, 255));
    endfunction

    task automatic queue_cmd(buf_cmd_t op, logic [CH_W-1:0] b);
        buf_item_t it;
        it.op   = op;
        it.ch   = b;
        it.hold = hold_next;
        hold_next = 1'b0;
        cmd_pending.push_back(it);
        n_queued++;
    endtask

    // command driver
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cmd_ch.valid   <= 1'b0;
            cmd_ch.command <= '0;
            cmd_ch.ch      <= '0;
        end else begin
            if (cmd_ch.valid && cmd_ch.ready) begin
                mon_want = apply_buffer_cmd(buf_cmd_t'(cmd_ch.command), cmd_ch.ch);
                res_expected.push_back(mon_want);
                n_cmd_done++;
                if (cmd_ch.command == CMD_FIND) begin
                    n_find++;
                    n_find_hit += mon_want.found;
                end
                if (cmd_ch.command == CMD_MATCH) begin
                    n_match++;
                    n_match_hit += mon_want.found;
                end
                n_overflow += mon_want.overflow;
            end
            if (!cmd_ch.valid || cmd_ch.ready) begin
                if (cmd_pending.size() != 0
                    && (!cmd_pending[0].hold || res_expected.size() == 0)
                    && (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    drv_next = cmd_pending.pop_front();
                    cmd_ch.valid   <= 1'b1;
                    cmd_ch.command <= drv_next.op;
                    cmd_ch.ch      <= drv_next.ch;
                end else begin
                    cmd_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    buf_result_t got_res;

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                n_res_done++;
                if (res_expected.size() == 0) begin
                    $error("result transfer with no command outstanding");
                    n_errors++;
                end else begin
                    got_res = res_expected.pop_front();
                    if (res_ch.text_len !== got_res.text_len) begin
                        $error("text_len: expected %0d, actual %0d",
                               got_res.text_len, res_ch.text_len);
                        n_errors++;
                    end
                    if (res_ch.found !== got_res.found) begin
                        $error("found: expected %0d, actual %0d", got_res.found, res_ch.found);
                        n_errors++;
                    end
                    if (res_ch.position !== got_res.position) begin
                        $error("position: expected %0d, actual %0d",
                               got_res.position, res_ch.position);
                        n_errors++;
                    end
                    if (res_ch.overflow !== got_res.overflow) begin
                        $error("overflow: expected %0d, actual %0d",
                               got_res.overflow, res_ch.overflow);
                        n_errors++;
                    end
                end
            end
            res_ch.ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // cycles with no transfer on either channel
    always @(posedge clk) begin
        if (rst_n) begin
            if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
                stall_cnt <= 0;
            else
                stall_cnt <= stall_cnt + 1;
        end
    end

    initial begin
        logic [CH_W-1:0] tbuf [$];
        logic [CH_W-1:0] pbuf [$];
        scen_t kind;
        int    iter;
        int    r;
        int    n;
        int    s;
        int    pl;
        bit    narrow;

        rst_n          = 1'b0;
        cmd_ch.valid   = 1'b0;
        cmd_ch.command = '0;
        cmd_ch.ch      = '0;
        res_ch.ready   = 1'b0;

        // empty stores, extreme bytes, every command
        queue_cmd(CMD_CLR_TEXT, 8'hFF);
        queue_cmd(CMD_MATCH, 8'h00);
        queue_cmd(CMD_FIND, 8'h00);
        queue_cmd(CMD_ADD_TEXT, 8'h00);
        queue_cmd(CMD_ADD_TEXT, 8'hFF);
        queue_cmd(CMD_ADD_TEXT, 8'h41);
        queue_cmd(CMD_ADD_TEXT, 8'hFF);
        queue_cmd(CMD_FIND, 8'hFF);
        queue_cmd(CMD_FIND, 8'h00);
        queue_cmd(CMD_FIND, 8'h7E);
        queue_cmd(CMD_CLR_PAT, 8'h00);
        queue_cmd(CMD_ADD_PAT, 8'hFF);
        queue_cmd(CMD_ADD_PAT, 8'h41);
        queue_cmd(CMD_MATCH, 8'hFF);
        queue_cmd(CMD_ADD_PAT, 8'h00);
        queue_cmd(CMD_MATCH, 8'h00);
        queue_cmd(CMD_ADD_PAT, 8'hFF);
        queue_cmd(CMD_ADD_PAT, 8'h80);
        queue_cmd(CMD_MATCH, 8'h00);
        queue_cmd(CMD_RSV6, 8'hAA);
        queue_cmd(CMD_RSV7, 8'h55);
        queue_cmd(CMD_CLR_PAT, 8'hFF);
        queue_cmd(CMD_MATCH, 8'h00);
        hold_next = 1'b1;
        queue_cmd(CMD_CLR_TEXT, 8'h00);

        iter = 0;
        while (n_queued < ITEM_TARGET) begin
            r = $urandom_range(0, 99);
            if (iter == 0 || iter == 90)
                kind = SC_FILL_TEXT;
            else if (iter == 1 || r < 2)
                kind = SC_FILL_PAT;
            else if (r < 60)
                kind = SC_PAIR;
            else if (r < 80)
                kind = SC_QUERY;
            else
                kind = SC_NOISE;
            if ($urandom_range(0, 29) == 0)
                hold_next = 1'b1;
            narrow = $urandom_range(0, 1);

            case (kind)
                SC_FILL_TEXT: begin
                    queue_cmd(CMD_CLR_TEXT, pick_byte(1'b0));
                    n = TEXT_DEPTH + $urandom_range(1, 3);
                    for (int i = 0; i < n; i++)
                        queue_cmd(CMD_ADD_TEXT, pick_byte(1'b0));
                    queue_cmd(CMD_FIND, pick_byte(1'b0));
                    queue_cmd(CMD_FIND, pick_byte(1'b0));
                    queue_cmd(CMD_MATCH, pick_byte(1'b0));
                end
                SC_FILL_PAT: begin
                    queue_cmd(CMD_CLR_PAT, pick_byte(1'b0));
                    n = PATTERN_DEPTH + $urandom_range(1, 3);
                    for (int i = 0; i < n; i++)
                        queue_cmd(CMD_ADD_PAT, pick_byte(narrow));
                    queue_cmd(CMD_MATCH, pick_byte(1'b0));
                end
                SC_PAIR: begin
                    tbuf.delete();
                    pbuf.delete();
                    n = ($urandom_range(0, 9) == 0) ? $urandom_range(21, 60)
                                                    : $urandom_range(0, 20);
                    if ($urandom_range(0, 99) < 85)
                        queue_cmd(CMD_CLR_TEXT, pick_byte(1'b0));
                    for (int i = 0; i < n; i++) begin
                        tbuf.push_back(pick_byte(narrow));
                        queue_cmd(CMD_ADD_TEXT, tbuf[i]);
                    end
                    r = $urandom_range(0, 99);
                    if (r < 60 && n > 0) begin
                        s  = $urandom_range(0, n - 1);
                        pl = $urandom_range(1, (n - s < 6) ? n - s : 6);
                        for (int k = 0; k < pl; k++)
                            pbuf.push_back(tbuf[s + k]);
                        if (r >= 40)
                            pbuf[$urandom_range(0, pl - 1)] ^= 8'h01 << $urandom_range(0, 7);
                    end else if (r < 80) begin
                        pl = $urandom_range(0, 4);
                        for (int k = 0; k < pl; k++)
                            pbuf.push_back(pick_byte(narrow));
                    end else begin
                        pl = n + $urandom_range(1, 3);
                        if (pl > PATTERN_DEPTH)
                            pl = PATTERN_DEPTH;
                        for (int k = 0; k < pl; k++)
                            pbuf.push_back(pick_byte(narrow));
                    end
                    queue_cmd(CMD_CLR_PAT, pick_byte(1'b0));
                    foreach (pbuf[k])
                        queue_cmd(CMD_ADD_PAT, pbuf[k]);
                    n = $urandom_range(1, 3);
                    for (int i = 0; i < n; i++) begin
                        if (tbuf.size() > 0 && $urandom_range(0, 1))
                            queue_cmd(CMD_FIND, tbuf[$urandom_range(0, tbuf.size() - 1)]);
                        else
                            queue_cmd(CMD_FIND, pick_byte(narrow));
                    end
                    n = $urandom_range(1, 2);
                    for (int i = 0; i < n; i++)
                        queue_cmd(CMD_MATCH, pick_byte(1'b0));
                end
                SC_QUERY: begin
                    n = $urandom_range(1, 4);
                    for (int i = 0; i < n; i++) begin
                        if ($urandom_range(0, 1))
                            queue_cmd(CMD_FIND, pick_byte(narrow));
                        else
                            queue_cmd(CMD_MATCH, pick_byte(1'b0));
                    end
                end
                default: begin
                    n = $urandom_range(1, 4);
                    for (int i = 0; i < n; i++)
                        queue_cmd(buf_cmd_t'($urandom_range(0, 7)), pick_byte(narrow));
                end
            endcase
            iter++;
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while ((cmd_pending.size() != 0 || cmd_ch.valid || res_expected.size() != 0)
               && stall_cnt < STALL_LIMIT)
            @(posedge clk);

        if (stall_cnt >= STALL_LIMIT) begin
            $display("timeout: %0d commands queued, %0d results still expected",
                     cmd_pending.size(), res_expected.size());
            $display("FAILURE");
            $finish;
        end else begin
            repeat (TAIL_CYCLES) @(posedge clk);
            if (res_expected.size() != 0) begin
                $error("%0d results never arrived", res_expected.size());
                n_errors++;
            end
            $display("ran %0d commands and checked %0d results: %0d finds (%0d hit), %0d matches (%0d hit)",
                     n_cmd_done, n_res_done, n_find, n_find_hit, n_match, n_match_hit);
            $display("%0d appends dropped on a full store, %0d mismatches", n_overflow, n_errors);
            if (n_errors == 0)
                $display("SUCCESS");
            else
                $display("FAILURE");
            $finish;
        end
    end

endmodule

### char_buffer_find_and_substring_match.f
+incdir+design
design/cbfsm_pkg.sv
design/cbfsm_if.sv
design/cbfsm_seq.sv
design/cbfsm_dp.sv
design/char_buffer_find_and_substring_match.sv
design/cbfsm_chk.sv
bench/char_buffer_find_and_substring_match_tb.sv
